// ===== sv/keyframe_curve_interpolator_top_macros.svh =====
// Assertion macros for the keyframe curve block.
`ifndef KEYFRAME_CURVE_INTERPOLATOR_TOP_MACROS_SVH
`define KEYFRAME_CURVE_INTERPOLATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define KCI_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KCI_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KCI_ASSERT(label, clk, rst, prop, msg)
`define KCI_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== sv/kci_pkg.sv =====
package kci_pkg;
  localparam int TABLE_DEPTH = 64;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DEL_AFTER = 2'd1,
    ACT_DEL_BEFORE = 2'd2,
    ACT_EVAL = 2'd3
  } action_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CHK,
    ST_INS_NEW,
    ST_SH_RD,
    ST_SH_WR,
    ST_INS_PUT,
    ST_DA_RD,
    ST_DA_CHK,
    ST_DB_RD,
    ST_DB_CHK,
    ST_DM_RD,
    ST_DM_WR,
    ST_EV_RD,
    ST_EV_CHK,
    ST_EV_RD0,
    ST_EV_LD,
    ST_EV_DIFF,
    ST_EV_MUL,
    ST_EV_DIV,
    ST_EV_WAIT,
    ST_MM_INIT,
    ST_MM_RD,
    ST_MM_ACC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [31:0] time_req;
    logic signed [31:0] value;
  } kci_in_t;

  typedef struct packed {
    logic signed [31:0] curve_value;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic [6:0] key_count;
    logic status;
  } kci_out_t;
endpackage

// ===== sv/kci_if.sv =====
interface kci_in_if import kci_pkg::*; ();
  logic valid;
  logic ready;
  logic [1:0] action;
  logic [31:0] time_req;
  logic signed [31:0] value;
  modport source (output valid, action, time_req, value, input ready);
  modport sink (input valid, action, time_req, value, output ready);
endinterface

interface kci_out_if import kci_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [31:0] curve_value;
  logic signed [31:0] min_value;
  logic signed [31:0] max_value;
  logic [6:0] key_count;
  logic status;
  modport source (output valid, curve_value, min_value, max_value, key_count, status,
                  input ready);
  modport sink (input valid, curve_value, min_value, max_value, key_count, status,
                output ready);
endinterface

// ===== sv/kci_div.sv =====
// Restoring divider: 64-bit numerator by 32-bit divisor, one bit per cycle.
module kci_div import kci_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic [63:0] quot,
  output logic        busy,
  output logic        done
);
  logic [63:0] q;
  logic [32:0] rem;
  logic [6:0] cnt;
  logic [32:0] trial;
  logic [32:0] sh;

  assign sh = {rem[31:0], q[63]};
  assign trial = sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q <= num;
        rem <= '0;
        cnt <= 7'd64;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          q <= {q[62:0], 1'b1};
        end else begin
          rem <= sh;
          q <= {q[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quot = q;
endmodule

// ===== sv/keyframe_curve_interpolator_top.sv =====
// Keyframe curve interpolator.
// Input channel in_ch carries action, time_req and value; output channel out_ch
// carries one result per accepted item: curve_value, min_value, max_value,
// key_count and status. Both use valid/ready; a transaction is taken when both
// are high.
// The 64-entry key table sits in two synchronous RAMs (time and value, one read
// per cycle, read data in the next cycle). One item is handled at a time and
// in_ch.ready is high only while the sequencer is idle.
// Each item walks the stored keys in turn; insert also moves every later key
// up by one entry, evaluate between two keys adds a product and a 64-step
// divide, and a min/max sweep over all stored keys ends every item. A new item
// is accepted only after the previous result has been taken.
// Reset clears the key count, the index and the state; the RAM contents need no
// clearing since only entries below the count are read.
// When the receiver stalls, the result is held in the output registers and no
// new item is accepted until it is taken.
`include "keyframe_curve_interpolator_top_macros.svh"
module keyframe_curve_interpolator_top import kci_pkg::*; (
  input logic clk,
  input logic rst,
  kci_in_if.sink in_ch,
  kci_out_if.source out_ch
);
  logic [31:0] tmem [TABLE_DEPTH];
  logic [31:0] vmem [TABLE_DEPTH];
  logic [AW-1:0] raddr, waddr;
  logic we;
  logic [31:0] wt, wv;
  logic [31:0] rt, rv;

  state_t state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] pos;
  logic [CW-1:0] drop;
  logic [31:0] treq;
  logic [31:0] vreq;
  logic stat;
  logic [31:0] curve;
  logic [31:0] t0, t1;
  logic signed [31:0] v0, v1;
  logic signed [32:0] dv;
  logic neg;
  logic [31:0] mag;
  logic [31:0] num;
  logic [31:0] span;
  logic [63:0] prod;
  logic [63:0] quot;
  logic div_start, div_busy, div_done;
  logic signed [31:0] mn, mx;

  always_ff @(posedge clk) begin
    if (we) begin
      tmem[waddr] <= wt;
      vmem[waddr] <= wv;
    end
    rt <= tmem[raddr];
    rv <= vmem[raddr];
  end

  kci_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(prod), .den(span),
    .quot(quot), .busy(div_busy), .done(div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  assign in_ch.ready = (state == ST_IDLE);
  assign out_ch.valid = (state == ST_OUT);

  assign dv = {v1[31], v1} - {v0[31], v0};

  always_comb begin
    state_next = state;
    raddr = idx[AW-1:0];
    we = 1'b0;
    waddr = idx[AW-1:0];
    wt = rt;
    wv = rv;
    div_start = 1'b0;
    case (state)
      ST_IDLE: if (in_ch.valid) begin
        case (action_t'(in_ch.action))
          ACT_INSERT: state_next = ST_INS_RD;
          ACT_DEL_AFTER: state_next = ST_DA_RD;
          ACT_DEL_BEFORE: state_next = ST_DB_RD;
          default: state_next = ST_EV_RD;
        endcase
      end
      ST_INS_RD: state_next = (idx == count) ? ST_INS_NEW : ST_INS_CHK;
      ST_INS_CHK: begin
        if (rt == treq) begin
          // equal time: overwrite the value in place
          we = 1'b1;
          wv = vreq;
          state_next = ST_MM_INIT;
        end else if (rt > treq) state_next = ST_INS_NEW;
        else state_next = ST_INS_RD;
      end
      ST_INS_NEW: begin
        if (count == CW'(TABLE_DEPTH)) state_next = ST_MM_INIT;
        else if (pos == count) state_next = ST_INS_PUT;
        else state_next = ST_SH_RD;
      end
      ST_SH_RD: begin
        raddr = AW'(idx - CW'(1));
        state_next = ST_SH_WR;
      end
      ST_SH_WR: begin
        we = 1'b1;
        state_next = (idx - CW'(1) == pos) ? ST_INS_PUT : ST_SH_RD;
      end
      ST_INS_PUT: begin
        we = 1'b1;
        waddr = pos[AW-1:0];
        wt = treq;
        wv = vreq;
        state_next = ST_MM_INIT;
      end
      ST_DA_RD: begin
        raddr = AW'(count - CW'(1));
        state_next = (count == '0) ? ST_MM_INIT : ST_DA_CHK;
      end
      ST_DA_CHK: state_next = (rt > treq) ? ST_DA_RD : ST_MM_INIT;
      ST_DB_RD: state_next = (idx == count) ? ST_DM_RD : ST_DB_CHK;
      ST_DB_CHK: begin
        if (rt < treq) state_next = ST_DB_RD;
        else if (idx == '0) state_next = ST_MM_INIT;
        else state_next = ST_DM_RD;
      end
      ST_DM_RD: state_next = (idx == count) ? ST_MM_INIT : ST_DM_WR;
      ST_DM_WR: begin
        we = 1'b1;
        waddr = AW'(idx - drop);
        state_next = ST_DM_RD;
      end
      ST_EV_RD: state_next = (count == '0) ? ST_MM_INIT : ST_EV_CHK;
      ST_EV_CHK: begin
        if (idx == '0) begin
          state_next = (count == CW'(1) || rt >= treq) ? ST_MM_INIT : ST_EV_RD;
        end else if (treq < rt) state_next = ST_EV_RD0;
        else if (idx == count - CW'(1)) state_next = ST_MM_INIT;
        else state_next = ST_EV_RD;
      end
      ST_EV_RD0: begin
        raddr = AW'(idx - CW'(1));
        state_next = ST_EV_LD;
      end
      ST_EV_LD: state_next = ST_EV_DIFF;
      ST_EV_DIFF: state_next = ST_EV_MUL;
      ST_EV_MUL: state_next = ST_EV_DIV;
      ST_EV_DIV: begin
        div_start = 1'b1;
        state_next = ST_EV_WAIT;
      end
      ST_EV_WAIT: if (div_done) state_next = ST_MM_INIT;
      ST_MM_INIT: state_next = ST_MM_RD;
      ST_MM_RD: state_next = (idx == count) ? ST_OUT : ST_MM_ACC;
      ST_MM_ACC: state_next = ST_MM_RD;
      ST_OUT: if (out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx <= '0;
    end else begin
      case (state)
        ST_IDLE: if (in_ch.valid) begin
          treq <= in_ch.time_req;
          vreq <= in_ch.value;
          stat <= 1'b0;
          curve <= '0;
          idx <= '0;
        end
        ST_INS_RD: if (idx == count) pos <= idx;
        ST_INS_CHK: begin
          if (rt > treq) pos <= idx;
          else if (rt != treq) idx <= idx + CW'(1);
        end
        ST_INS_NEW: begin
          if (count == CW'(TABLE_DEPTH)) stat <= 1'b1;
          else idx <= count;
        end
        ST_SH_WR: idx <= idx - CW'(1);
        ST_INS_PUT: count <= count + CW'(1);
        ST_DA_CHK: if (rt > treq) count <= count - CW'(1);
        ST_DB_RD: if (idx == count) drop <= idx;
        ST_DB_CHK: begin
          if (rt < treq) idx <= idx + CW'(1);
          else drop <= idx;
        end
        ST_DM_RD: if (idx == count) count <= count - drop;
        ST_DM_WR: idx <= idx + CW'(1);
        ST_EV_CHK: begin
          if (idx == '0) begin
            if (count == CW'(1) || rt >= treq) curve <= rv;
            else idx <= idx + CW'(1);
          end else if (treq < rt) begin
            t1 <= rt;
            v1 <= rv;
          end else if (idx == count - CW'(1)) curve <= rv;
          else idx <= idx + CW'(1);
        end
        ST_EV_LD: begin
          t0 <= rt;
          v0 <= rv;
        end
        ST_EV_DIFF: begin
          neg <= dv[32];
          mag <= dv[32] ? 32'(-dv) : dv[31:0];
          num <= treq - t0;
          span <= t1 - t0;
        end
        ST_EV_MUL: prod <= 64'(mag) * 64'(num);
        ST_EV_WAIT: if (div_done) begin
          // quotient is below |v1 - v0|, so the sum stays between v0 and v1
          curve <= neg ? 32'({v0[31], v0} - {1'b0, quot[31:0]})
                       : 32'({v0[31], v0} + {1'b0, quot[31:0]});
        end
        ST_MM_INIT: begin
          idx <= '0;
          mn <= '0;
          mx <= '0;
        end
        ST_MM_ACC: begin
          if (idx == '0 || $signed(rv) < mn) mn <= rv;
          if (idx == '0 || $signed(rv) > mx) mx <= rv;
          idx <= idx + CW'(1);
        end
        default: ;
      endcase
    end
  end

  assign out_ch.curve_value = curve;
  assign out_ch.min_value = mn;
  assign out_ch.max_value = mx;
  assign out_ch.key_count = 7'(count);
  assign out_ch.status = stat;

  `KCI_ASSERT(a_cnt_range, clk, rst, count <= CW'(TABLE_DEPTH), "count above depth")
  `KCI_ASSERT(a_one_state, clk, rst, !(in_ch.ready && out_ch.valid), "ready while holding")
  `KCI_ASSERT(a_hold, clk, rst, out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(curve) && $stable(count), "result changed under stall")
  `KCI_ASSERT(a_div_start, clk, rst, div_start |-> !div_busy, "divider restarted while busy")
  `KCI_ASSERT_ALWAYS(a_rst_idle, clk, rst |=> state == ST_IDLE, "not idle after reset")
endmodule
